### rtl/wspi_pkg.sv
// shared types and constants for the wheel speed pi controller
package wspi_pkg;

	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_GAIN = 2'd1,
		OP_BPX  = 2'd2,
		OP_BPY  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_ACK  = 2'd0,
		ACT_STOP = 2'd1,
		ACT_CW   = 2'd2,
		ACT_CCW  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPEED,
		S_ERR,
		S_P0,
		S_P1,
		S_P2,
		S_P3,
		S_SRCH,
		S_PREV,
		S_DINIT,
		S_DIV,
		S_DUTY,
		S_DONE
	} state_t;

	localparam int GAINS_PER_DIR = 3;
	localparam int FULL_PERCENT  = 100;
	localparam int QUOT_BITS     = 41;
	localparam int WIDE_W        = 68;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(signed'(32'sh7fffffff));
		lo = WIDE_W'(signed'(32'sh80000000));
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

### rtl/wheel_speed_pi_with_inverse_nonlinearity_core.sv
// wheel speed pi controller with piecewise linear duty compensation
//
// channel   direction  handshake        payload
// config    in         cfg_we           cfg_wdata
// item      in         start & !busy    opcode .. entry_value
// result    out        done (1 cycle)   motor_index_out, action, duty, control_value
//
// writes, stops and out-of-range motors give their result beat in the cycle after accept
// a control step runs speed, error, the three pi products and a breakpoint search that
// probes entries until one is above u (straight to the result when none is), then the
// one-bit-per-cycle restoring divider when a segment is interpolated without saturation
// one shared 33x33 multiplier does speed, the three pi products and dy*t
// busy stays high until the result cycle ends; the receiver cannot stall
// arst_n clears control state and history; tables stay undefined until written
module wheel_speed_pi_with_inverse_nonlinearity_core
	import wspi_pkg::*;
#(
	parameter int MOTOR_COUNT      = 3,
	parameter int BREAKPOINT_COUNT = 18,
	parameter int FRACTION_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [30:0]                 cfg_wdata,
	input  logic                        start,
	input  logic [1:0]                  opcode,
	input  logic [1:0]                  motor_index,
	input  logic signed [15:0]          tick_count,
	input  logic signed [31:0]          setpoint,
	input  logic                        saturated,
	input  logic                        table_direction,
	input  logic [4:0]                  entry_index,
	input  logic signed [31:0]          entry_value,
	output logic                        busy,
	output logic                        done,
	output logic [1:0]                  motor_index_out,
	output logic [1:0]                  action,
	output logic [FRACTION_BITS+6:0]    duty,
	output logic signed [31:0]          control_value
);

	localparam int DUTY_W  = FRACTION_BITS + 7;
	localparam int GAIN_N  = MOTOR_COUNT * 2 * GAINS_PER_DIR;
	localparam int GAIN_AW = $clog2(GAIN_N);
	localparam int BP_N    = MOTOR_COUNT * 2 * BREAKPOINT_COUNT;
	localparam int BP_AW   = $clog2(BP_N);
	localparam int IDX_W   = $clog2(BREAKPOINT_COUNT);
	localparam int MOT_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(FULL_PERCENT) << FRACTION_BITS;
	localparam logic [QUOT_BITS:0] QLIM = (QUOT_BITS+1)'(1) << (QUOT_BITS - 1);

	state_t state_q, state_d;

	logic [30:0]              spt_q;
	logic [1:0]               motor_q;
	logic                     dir_q;
	logic                     sat_q;
	logic signed [15:0]       ticks_q;
	logic signed [31:0]       sp_q;
	logic signed [31:0]       e_q;
	logic signed [31:0]       u_q;
	logic signed [WIDE_W-1:0] acc_q;
	logic signed [65:0]       prod_q;
	logic [IDX_W-1:0]         idx_q, rd_idx_d;
	logic signed [31:0]       xi_q, yi_q, yp_q;
	logic [32:0]              dx_q;
	logic                     neg_q, lim_q, qz_q;
	logic [32:0]              rem_q;
	logic [QUOT_BITS-1:0]     dvd_q;
	logic [5:0]               cnt_q;
	logic [1:0]               action_q;
	logic [DUTY_W-1:0]        duty_q;
	logic signed [31:0]       cv_q;
	logic signed [31:0]       eh_q [MOTOR_COUNT];
	logic signed [31:0]       uh_q [MOTOR_COUNT];
	logic signed [31:0]       gain_q [GAIN_N];
	logic signed [31:0]       x_mem [BP_N];
	logic signed [31:0]       y_mem [BP_N];
	logic signed [31:0]       x_rd_q, y_rd_q;

	logic                     acc_in, m_ok, found, last;
	logic [MOT_W-1:0]         mi;
	logic [1:0]               gk;
	logic [GAIN_AW-1:0]       gidx;
	logic signed [31:0]       gain_rd;
	logic signed [32:0]       mul_a, mul_b;
	logic signed [65:0]       prod;
	logic signed [65:0]       prod_sh;
	logic signed [WIDE_W-1:0] prod_ext;
	logic [BP_AW-1:0]         wr_addr, rd_addr;
	logic signed [32:0]       dx, dy, tt;
	logic [65:0]              mag;
	logic                     lim_now;
	logic [33:0]              rem2;
	logic                     ge;
	logic [QUOT_BITS:0]       qv;
	logic signed [QUOT_BITS+1:0] dsum;
	logic signed [WIDE_W-1:0] spd_ext, absp, diff;
	logic signed [31:0]       speed;

	assign acc_in = start && !busy;
	assign m_ok   = int'(motor_index) < MOTOR_COUNT;
	assign mi     = MOT_W'(motor_q);
	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_DONE;

	assign motor_index_out = motor_q;
	assign action          = action_q;
	assign duty            = duty_q;
	assign control_value   = cv_q;

	assign found = x_rd_q > u_q;
	assign last  = idx_q == IDX_W'(BREAKPOINT_COUNT - 1);

	assign gidx    = GAIN_AW'(int'(motor_q) * 2 * GAINS_PER_DIR + int'(dir_q) * GAINS_PER_DIR
		+ int'(gk));
	assign gain_rd = gain_q[gidx];
	assign prod    = mul_a * mul_b;
	assign prod_sh = prod_q >>> FRACTION_BITS;
	assign prod_ext = sat_q ? '0 : WIDE_W'(prod_sh);

	assign wr_addr = BP_AW'((int'(motor_index) * 2 + int'(table_direction)) * BREAKPOINT_COUNT
		+ int'(entry_index));
	assign rd_addr = BP_AW'((int'(motor_q) * 2 + int'(dir_q)) * BREAKPOINT_COUNT
		+ int'(rd_idx_d));

	assign spd_ext = WIDE_W'(prod_q);
	assign speed   = sat32(spd_ext);
	assign absp    = (sp_q < 0) ? -WIDE_W'(sp_q) : WIDE_W'(sp_q);
	assign diff    = absp - WIDE_W'(speed);

	assign dx = 33'(xi_q) - 33'(x_rd_q);
	assign dy = 33'(yi_q) - 33'(y_rd_q);
	assign tt = 33'(u_q) - 33'(x_rd_q);

	assign mag     = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	assign lim_now = mag[64] || (33'(mag[64:QUOT_BITS]) >= dx_q);
	assign rem2    = {rem_q, dvd_q[QUOT_BITS-1]};
	assign ge      = rem2 >= {1'b0, dx_q};

	always_comb begin
		if (lim_q) begin
			qv = QLIM;
		end else if (qz_q) begin
			qv = '0;
		end else if ({1'b0, dvd_q} > QLIM) begin
			qv = QLIM;
		end else begin
			qv = {1'b0, dvd_q};
		end
		dsum = neg_q ? (QUOT_BITS+2)'(yp_q) - signed'({1'b0, qv})
			: (QUOT_BITS+2)'(yp_q) + signed'({1'b0, qv});
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					if (opcode != OP_STEP || !m_ok || setpoint == 0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SPEED;
					end
				end
			end
			S_SPEED: state_d = S_ERR;
			S_ERR:   state_d = S_P0;
			S_P0:    state_d = S_P1;
			S_P1:    state_d = S_P2;
			S_P2:    state_d = S_P3;
			S_P3:    state_d = S_SRCH;
			S_SRCH: begin
				if (found) begin
					state_d = S_PREV;
				end else if (last) begin
					state_d = S_DONE;
				end
			end
			S_PREV:  state_d = (dx > 0) ? S_DINIT : S_DUTY;
			S_DINIT: state_d = lim_now ? S_DUTY : S_DIV;
			S_DIV:   state_d = (cnt_q == 6'd1) ? S_DUTY : S_DIV;
			S_DUTY:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// shared multiplier operands and table read pointer
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		gk       = 2'd0;
		rd_idx_d = idx_q;
		unique case (state_q)
			S_SPEED: begin
				mul_a = 33'(ticks_q);
				mul_b = signed'({2'b0, spt_q});
			end
			S_P0: begin
				gk    = 2'd0;
				mul_a = 33'(gain_rd);
				mul_b = 33'(e_q);
			end
			S_P1: begin
				gk    = 2'd1;
				mul_a = 33'(gain_rd);
				mul_b = 33'(eh_q[mi]);
			end
			S_P2: begin
				gk    = 2'd2;
				mul_a = 33'(gain_rd);
				mul_b = 33'(uh_q[mi]);
			end
			S_P3: rd_idx_d = IDX_W'(1);
			S_SRCH: begin
				if (found) begin
					rd_idx_d = idx_q - IDX_W'(1);
				end else if (!last) begin
					rd_idx_d = idx_q + IDX_W'(1);
				end
			end
			S_PREV: begin
				mul_a = dy;
				mul_b = tt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			spt_q   <= 31'd65536;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				eh_q[i] <= '0;
				uh_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				spt_q <= cfg_wdata;
			end
			if (state_q == S_DUTY) begin
				eh_q[mi] <= e_q;
				uh_q[mi] <= u_q;
			end
		end
	end

	// tables
	always_ff @(posedge clk) begin
		if (acc_in && m_ok && opcode == OP_GAIN && int'(entry_index) < GAINS_PER_DIR) begin
			gain_q[GAIN_AW'(int'(motor_index) * 2 * GAINS_PER_DIR
				+ int'(table_direction) * GAINS_PER_DIR + int'(entry_index))] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && m_ok && opcode == OP_BPX && int'(entry_index) < BREAKPOINT_COUNT) begin
			x_mem[wr_addr] <= entry_value;
		end
		x_rd_q <= x_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_in && m_ok && opcode == OP_BPY && int'(entry_index) < BREAKPOINT_COUNT) begin
			y_mem[wr_addr] <= entry_value;
		end
		y_rd_q <= y_mem[rd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		idx_q <= rd_idx_d;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					motor_q  <= motor_index;
					dir_q    <= setpoint < 0;
					sat_q    <= saturated;
					ticks_q  <= tick_count;
					sp_q     <= setpoint;
					action_q <= (opcode != OP_STEP) ? ACT_ACK : ACT_STOP;
					duty_q   <= '0;
					cv_q     <= '0;
				end
			end
			S_SPEED: prod_q <= prod;
			S_ERR:   e_q <= sat32(diff);
			S_P0:    prod_q <= prod;
			S_P1: begin
				acc_q  <= WIDE_W'(prod_sh);
				prod_q <= prod;
			end
			S_P2: begin
				acc_q  <= acc_q + prod_ext;
				prod_q <= prod;
			end
			S_P3: u_q <= sat32(acc_q + prod_ext);
			S_SRCH: begin
				xi_q     <= x_rd_q;
				yi_q     <= y_rd_q;
				action_q <= dir_q ? ACT_CCW : ACT_CW;
				cv_q     <= u_q;
				duty_q   <= DUTY_FULL;
			end
			S_PREV: begin
				yp_q   <= y_rd_q;
				dx_q   <= dx[32:0];
				qz_q   <= !(dx > 0);
				lim_q  <= 1'b0;
				neg_q  <= 1'b0;
				prod_q <= prod;
			end
			S_DINIT: begin
				neg_q <= prod_q[65];
				lim_q <= lim_now;
				rem_q <= 33'(mag[64:QUOT_BITS]);
				dvd_q <= mag[QUOT_BITS-1:0];
				cnt_q <= 6'(QUOT_BITS);
			end
			S_DIV: begin
				rem_q <= ge ? 33'(rem2 - {1'b0, dx_q}) : rem2[32:0];
				dvd_q <= {dvd_q[QUOT_BITS-2:0], ge};
				cnt_q <= cnt_q - 6'd1;
			end
			S_DUTY: begin
				if (dsum < 0) begin
					duty_q <= '0;
				end else if (dsum > signed'((QUOT_BITS+2)'(DUTY_FULL))) begin
					duty_q <= DUTY_FULL;
				end else begin
					duty_q <= dsum[DUTY_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/wspi_checker.sv
// port checker for the wheel speed pi controller
module wspi_checker
	import wspi_pkg::*;
#(
	parameter int DUTY_W = 23
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic [1:0]               action,
	input logic [DUTY_W-1:0]        duty,
	input logic signed [31:0]       control_value
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("no busy after accept");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result outside busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result beat repeated");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (action == ACT_ACK || action == ACT_STOP) |-> duty == 0 && control_value == 0)
		else $error("nonzero payload on ack or stop");

endmodule

bind wheel_speed_pi_with_inverse_nonlinearity_core wspi_checker #(
	.DUTY_W(FRACTION_BITS + 7)
) u_wspi_checker (.*);
